/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the boot sector geometry block.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define FBSG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define FBSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FBSG_ASSERT_IMPL(lbl, ante, cons, msg)
`define FBSG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/fbsg_pkg.sv */
// Shared types and constants for the FAT boot sector geometry pipeline.
// No dependencies; the decode, span, classify and top-level files refer to it by scoped names.
`default_nettype none

package fbsg_pkg;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BAD  = 2'd1,
    ST_OVER = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    KIND_FAT12 = 2'd0,
    KIND_FAT16 = 2'd1,
    KIND_FAT32 = 2'd2
  } kind_e;

  localparam logic [7:0]  JMP_REL16     = 8'hE9;
  localparam logic [7:0]  JMP_REL8      = 8'hEB;
  localparam logic [7:0]  JUMP_NOP      = 8'h90;
  localparam logic [7:0]  MEDIA_FIXED   = 8'hF0;
  localparam logic [7:0]  MEDIA_LOW     = 8'hF8;
  localparam logic [31:0] FAT12_LIMIT   = 32'd4085;
  localparam logic [31:0] FAT16_LIMIT   = 32'd65525;
  localparam logic [27:0] FAT16_EOC     = 28'h000FFF8;
  localparam logic [27:0] FAT32_EOC     = 28'hFFFFFF8;
  localparam logic [27:0] MASK_FAT16    = 28'h000FFFF;
  localparam logic [27:0] MASK_FAT32    = 28'hFFFFFFF;
  localparam logic [2:0]  FAT16_EBYTES  = 3'd2;
  localparam logic [2:0]  FAT32_EBYTES  = 3'd4;

  // after decode
  typedef struct packed {
    logic        bad;
    logic [15:0] rsv;
    logic [7:0]  nfat;
    logic [31:0] fsz;
    logic [12:0] root;
    logic [31:0] tot;
    logic [2:0]  cshift;
  } dec_t;

  // after FAT area multiply
  typedef struct packed {
    logic        bad;
    logic [15:0] rsv;
    logic [39:0] prod;
    logic [31:0] fsz;
    logic [12:0] root;
    logic [31:0] tot;
    logic [2:0]  cshift;
  } mul_t;

  // after first data sector sum
  typedef struct packed {
    logic        bad;
    logic        over;
    logic [39:0] first;
    logic [31:0] fsz;
    logic [12:0] root;
    logic [31:0] tot;
    logic [2:0]  cshift;
  } sum_t;

  typedef struct packed {
    status_e     status;
    kind_e       fat_kind;
    logic [12:0] root_dir_sectors;
    logic [31:0] fat_sectors;
    logic [31:0] cluster_count;
    logic [39:0] first_data_sector;
    logic [2:0]  entry_bytes;
    logic [27:0] end_marker;
    logic [27:0] entry_mask;
  } res_t;

endpackage

`default_nettype wire

/* rtl/fbsg_in_if.sv */
// Input channel: one decoded boot parameter block per transaction.
// Standalone; no package dependency.
`default_nettype none

interface fbsg_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  jump_first;
  logic [7:0]  jump_third;
  logic [15:0] bytes_per_sector;
  logic [7:0]  sectors_per_cluster;
  logic [15:0] reserved_sectors;
  logic [7:0]  fat_copies;
  logic [15:0] root_entries;
  logic [15:0] total_sectors_short;
  logic [7:0]  media_byte;
  logic [15:0] fat_size_short;
  logic [31:0] total_sectors_long;
  logic [31:0] fat_size_long;

  modport source (
    output valid, jump_first, jump_third, bytes_per_sector, sectors_per_cluster,
           reserved_sectors, fat_copies, root_entries, total_sectors_short,
           media_byte, fat_size_short, total_sectors_long, fat_size_long,
    input  ready
  );
  modport sink (
    input  valid, jump_first, jump_third, bytes_per_sector, sectors_per_cluster,
           reserved_sectors, fat_copies, root_entries, total_sectors_short,
           media_byte, fat_size_short, total_sectors_long, fat_size_long,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/fbsg_out_if.sv */
// Output channel: one geometry result per transaction.
// Standalone; no package dependency.
`default_nettype none

interface fbsg_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  fat_kind;
  logic [12:0] root_dir_sectors;
  logic [31:0] fat_sectors;
  logic [31:0] cluster_count;
  logic [39:0] first_data_sector;
  logic [2:0]  entry_bytes;
  logic [27:0] end_marker;
  logic [27:0] entry_mask;

  modport source (
    output valid, status, fat_kind, root_dir_sectors, fat_sectors, cluster_count,
           first_data_sector, entry_bytes, end_marker, entry_mask,
    input  ready
  );
  modport sink (
    input  valid, status, fat_kind, root_dir_sectors, fat_sectors, cluster_count,
           first_data_sector, entry_bytes, end_marker, entry_mask,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/fbsg_decode.sv */
// Stage 1: field checks, sector and cluster shift decode, root directory size,
// FAT size and total sector selection. Uses fbsg_pkg and fbsg_in_if.
`default_nettype none

module fbsg_decode (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  fbsg_in_if.sink             in_i,
  output fbsg_pkg::dec_t      dec_o,
  output logic                valid_o,
  input  wire logic           ready_i
);

  logic           valid_q;
  fbsg_pkg::dec_t dec_q, dec_d;
  logic           advance;

  logic        jump_ok, media_ok, spc_ok, bps_ok;
  logic [3:0]  sshift;
  logic [2:0]  cshift;
  logic [12:0] bps_m1;
  logic [21:0] root_sum, root_shr;

  assign advance    = !valid_q || ready_i;
  assign in_i.ready = advance;

  always_comb begin
    jump_ok  = (in_i.jump_first == fbsg_pkg::JMP_REL16) ||
               ((in_i.jump_first == fbsg_pkg::JMP_REL8) &&
                (in_i.jump_third == fbsg_pkg::JUMP_NOP));
    media_ok = (in_i.media_byte == fbsg_pkg::MEDIA_FIXED) ||
               (in_i.media_byte >= fbsg_pkg::MEDIA_LOW);
    spc_ok   = $onehot(in_i.sectors_per_cluster);

    case (in_i.bytes_per_sector)
      16'd512:  begin sshift = 4'd9;  bps_ok = 1'b1; end
      16'd1024: begin sshift = 4'd10; bps_ok = 1'b1; end
      16'd2048: begin sshift = 4'd11; bps_ok = 1'b1; end
      16'd4096: begin sshift = 4'd12; bps_ok = 1'b1; end
      default:  begin sshift = 4'd9;  bps_ok = 1'b0; end
    endcase

    cshift = 3'd0;
    for (int i = 0; i < 8; i++) begin
      if (in_i.sectors_per_cluster[i]) cshift = 3'(i);
    end

    // round up: (entries * 32 + bps - 1) >> log2(bps)
    bps_m1   = in_i.bytes_per_sector[12:0] - 13'd1;
    root_sum = {1'b0, in_i.root_entries, 5'b0} + {9'b0, bps_m1};
    root_shr = root_sum >> sshift;

    dec_d = '0;
    dec_d.bad = !(jump_ok && bps_ok && spc_ok && media_ok &&
                  (in_i.reserved_sectors != 16'd0) && (in_i.fat_copies != 8'd0));
    if (!dec_d.bad) begin
      dec_d.rsv    = in_i.reserved_sectors;
      dec_d.nfat   = in_i.fat_copies;
      dec_d.fsz    = (in_i.fat_size_short != 16'd0) ? {16'b0, in_i.fat_size_short}
                                                    : in_i.fat_size_long;
      dec_d.tot    = (in_i.total_sectors_short != 16'd0)
                     ? {16'b0, in_i.total_sectors_short} : in_i.total_sectors_long;
      dec_d.root   = root_shr[12:0];
      dec_d.cshift = cshift;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_i.valid) begin
      dec_q <= dec_d;
    end
  end

  assign dec_o   = dec_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

/* rtl/fbsg_span.sv */
// Stages 2 and 3: FAT area multiply, then first data sector sum and the
// overhead check against the total sector count. Uses fbsg_pkg.
`default_nettype none

module fbsg_span (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fbsg_pkg::dec_t dec_i,
  input  wire logic           valid_i,
  output logic                ready_o,
  output fbsg_pkg::sum_t      sum_o,
  output logic                valid_o,
  input  wire logic           ready_i
);

  logic           mul_valid_q, sum_valid_q;
  fbsg_pkg::mul_t mul_q, mul_d;
  fbsg_pkg::sum_t sum_q, sum_d;
  logic           mul_adv, sum_adv;

  assign sum_adv = !sum_valid_q || ready_i;
  assign mul_adv = !mul_valid_q || sum_adv;
  assign ready_o = mul_adv;

  always_comb begin
    mul_d        = '0;
    mul_d.bad    = dec_i.bad;
    mul_d.rsv    = dec_i.rsv;
    mul_d.prod   = 40'(dec_i.nfat) * 40'(dec_i.fsz);
    mul_d.fsz    = dec_i.fsz;
    mul_d.root   = dec_i.root;
    mul_d.tot    = dec_i.tot;
    mul_d.cshift = dec_i.cshift;
  end

  always_comb begin
    sum_d        = '0;
    sum_d.bad    = mul_q.bad;
    sum_d.first  = mul_q.prod + {24'b0, mul_q.rsv} + {27'b0, mul_q.root};
    sum_d.over   = sum_d.first > {8'b0, mul_q.tot};
    sum_d.fsz    = mul_q.fsz;
    sum_d.root   = mul_q.root;
    sum_d.tot    = mul_q.tot;
    sum_d.cshift = mul_q.cshift;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      sum_valid_q <= 1'b0;
    end else begin
      if (mul_adv) mul_valid_q <= valid_i;
      if (sum_adv) sum_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_adv && valid_i)     mul_q <= mul_d;
    if (sum_adv && mul_valid_q) sum_q <= sum_d;
  end

  assign sum_o   = sum_q;
  assign valid_o = sum_valid_q;

endmodule

`default_nettype wire

/* rtl/fbsg_classify.sv */
// Stage 4: cluster count, FAT type and per-type constants into the output
// register. Uses fbsg_pkg, fbsg_out_if and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module fbsg_classify (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire fbsg_pkg::sum_t sum_i,
  input  wire logic           valid_i,
  output logic                ready_o,
  fbsg_out_if.source          out_o
);

  logic           valid_q;
  fbsg_pkg::res_t res_q, res_d;
  logic           advance;
  logic [31:0]    data_secs, clusters;

  assign advance = !valid_q || out_o.ready;
  assign ready_o = advance;

  always_comb begin
    data_secs = sum_i.tot - sum_i.first[31:0];
    clusters  = data_secs >> sum_i.cshift;
    res_d     = '0;
    if (sum_i.bad) begin
      res_d.status = fbsg_pkg::ST_BAD;
    end else begin
      res_d.root_dir_sectors  = sum_i.root;
      res_d.fat_sectors       = sum_i.fsz;
      res_d.first_data_sector = sum_i.first;
      if (sum_i.over) begin
        res_d.status = fbsg_pkg::ST_OVER;
      end else begin
        res_d.status        = fbsg_pkg::ST_OK;
        res_d.cluster_count = clusters;
        if (clusters < fbsg_pkg::FAT12_LIMIT) begin
          res_d.fat_kind = fbsg_pkg::KIND_FAT12;
        end else if (clusters < fbsg_pkg::FAT16_LIMIT) begin
          res_d.fat_kind    = fbsg_pkg::KIND_FAT16;
          res_d.entry_bytes = fbsg_pkg::FAT16_EBYTES;
          res_d.end_marker  = fbsg_pkg::FAT16_EOC;
          res_d.entry_mask  = fbsg_pkg::MASK_FAT16;
        end else begin
          res_d.fat_kind    = fbsg_pkg::KIND_FAT32;
          res_d.entry_bytes = fbsg_pkg::FAT32_EBYTES;
          res_d.end_marker  = fbsg_pkg::FAT32_EOC;
          res_d.entry_mask  = fbsg_pkg::MASK_FAT32;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && valid_i) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid             = valid_q;
  assign out_o.status            = res_q.status;
  assign out_o.fat_kind          = res_q.fat_kind;
  assign out_o.root_dir_sectors  = res_q.root_dir_sectors;
  assign out_o.fat_sectors       = res_q.fat_sectors;
  assign out_o.cluster_count     = res_q.cluster_count;
  assign out_o.first_data_sector = res_q.first_data_sector;
  assign out_o.entry_bytes       = res_q.entry_bytes;
  assign out_o.end_marker        = res_q.end_marker;
  assign out_o.entry_mask        = res_q.entry_mask;

  `FBSG_ASSERT_IMPL(a_bad_zero, valid_q && res_q.status == fbsg_pkg::ST_BAD, res_q.first_data_sector == 40'd0 && res_q.fat_sectors == 32'd0 && res_q.entry_mask == 28'd0, "invalid block carries nonzero geometry")
  `FBSG_ASSERT_IMPL(a_over_no_clusters, valid_q && res_q.status == fbsg_pkg::ST_OVER, res_q.cluster_count == 32'd0 && res_q.fat_kind == fbsg_pkg::KIND_FAT12, "overhead error with clusters or type")
  `FBSG_ASSERT_IMPL(a_fat12_no_entry, valid_q && res_q.fat_kind == fbsg_pkg::KIND_FAT12, res_q.entry_bytes == 3'd0 && res_q.end_marker == 28'd0, "FAT12 result with entry constants")
  `FBSG_ASSERT_IMPL(a_fat32_count, valid_q && res_q.fat_kind == fbsg_pkg::KIND_FAT32, res_q.cluster_count >= fbsg_pkg::FAT16_LIMIT, "FAT32 below cluster threshold")
  `FBSG_ASSERT_NEXT(a_hold_stall, valid_q && !out_o.ready, valid_q && $stable(res_q), "result changed under stall")

endmodule

`default_nettype wire

/* rtl/fat_boot_sector_geometry.sv */
// Top level of the FAT boot sector geometry checker: four-stage pipeline.
// Depends on fbsg_pkg, fbsg_in_if, fbsg_out_if and the three stage modules.
//
//   channel | dir | modport | payload
//   in_i    | in  | sink    | decoded boot parameter block fields
//   out_o   | out | source  | status, FAT type and volume geometry
//
// Four register stages: a result passes the decode, multiply, sum and output registers
// in turn; one item is taken every cycle unless the output stalls. Stages: decode and
// checks, FAT area multiply (8x32), first data sector add and overhead compare, cluster
// shift and type select. Reset clears only the per-stage valid bits. Each stage holds
// under a stall and a bubble in any stage lets the stages before it keep advancing.
`default_nettype none

module fat_boot_sector_geometry (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fbsg_in_if.sink    in_i,
  fbsg_out_if.source out_o
);

  fbsg_pkg::dec_t dec;
  fbsg_pkg::sum_t sum;
  logic           dec_valid, dec_ready;
  logic           sum_valid, sum_ready;

  fbsg_decode u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .dec_o   (dec),
    .valid_o (dec_valid),
    .ready_i (dec_ready)
  );

  fbsg_span u_span (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .dec_i   (dec),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .sum_o   (sum),
    .valid_o (sum_valid),
    .ready_i (sum_ready)
  );

  fbsg_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sum_i   (sum),
    .valid_i (sum_valid),
    .ready_o (sum_ready),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

/* verif/fat_boot_sector_geometry_tb.sv */
// Self-checking testbench for fat_boot_sector_geometry: predicts each geometry result
// from the accepted parameter block and checks results in order of arrival.
// Depends on fbsg_pkg, fbsg_in_if, fbsg_out_if and the RTL of the block.
module fat_boot_sector_geometry_tb;

  localparam int RANDOM_ITEMS = 1030;
  localparam int QUIET_ITEMS  = 150;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [7:0]  jump_first;
    logic [7:0]  jump_third;
    logic [15:0] bytes_per_sector;
    logic [7:0]  sectors_per_cluster;
    logic [15:0] reserved_sectors;
    logic [7:0]  fat_copies;
    logic [15:0] root_entries;
    logic [15:0] total_sectors_short;
    logic [7:0]  media_byte;
    logic [15:0] fat_size_short;
    logic [31:0] total_sectors_long;
    logic [31:0] fat_size_long;
  } bpb_t;

  typedef enum {TOT_BELOW, TOT_EQUAL, TOT_CLUSTERS} tot_mode_e;
  typedef enum {
    BREAK_JUMP, BREAK_NOP, BREAK_SECTOR, BREAK_CLUSTER,
    BREAK_RESERVED, BREAK_COPIES, BREAK_MEDIA
  } fault_e;

  class geometry_scoreboard;
    fbsg_pkg::res_t expected_geometry[$];
    int unsigned    mismatches;

    static function fbsg_pkg::res_t geometry_of(bpb_t b);
      fbsg_pkg::res_t r;
      logic [63:0]    root, fsz, tot, first, clusters;
      int unsigned    sshift, cshift;
      logic           jump_ok, spc_ok, media_ok;
      r = '0;
      jump_ok = (b.jump_first == fbsg_pkg::JMP_REL16) ||
                (b.jump_first == fbsg_pkg::JMP_REL8 && b.jump_third == fbsg_pkg::JUMP_NOP);
      case (b.bytes_per_sector)
        16'd512:  sshift = 9;
        16'd1024: sshift = 10;
        16'd2048: sshift = 11;
        16'd4096: sshift = 12;
        default:  sshift = 0;
      endcase
      spc_ok = (b.sectors_per_cluster != 8'd0) &&
               ((b.sectors_per_cluster & (b.sectors_per_cluster - 8'd1)) == 8'd0);
      media_ok = (b.media_byte == fbsg_pkg::MEDIA_FIXED) ||
                 (b.media_byte >= fbsg_pkg::MEDIA_LOW);
      if (!jump_ok || sshift == 0 || !spc_ok || b.reserved_sectors == 16'd0 ||
          b.fat_copies == 8'd0 || !media_ok) begin
        r.status = fbsg_pkg::ST_BAD;
        return r;
      end
      cshift = 0;
      while ((1 << cshift) < int'(b.sectors_per_cluster))
        cshift++;
      root = ((64'(b.root_entries) << 5) + 64'(b.bytes_per_sector) - 64'd1) >> sshift;
      fsz = (b.fat_size_short != 16'd0) ? 64'(b.fat_size_short) : 64'(b.fat_size_long);
      tot = (b.total_sectors_short != 16'd0) ? 64'(b.total_sectors_short)
                                             : 64'(b.total_sectors_long);
      first = 64'(b.reserved_sectors) + 64'(b.fat_copies) * fsz + root;
      r.root_dir_sectors  = root[12:0];
      r.fat_sectors       = fsz[31:0];
      r.first_data_sector = first[39:0];
      if (first > tot) begin
        r.status = fbsg_pkg::ST_OVER;
        return r;
      end
      clusters = (tot - first) >> cshift;
      r.status = fbsg_pkg::ST_OK;
      r.cluster_count = clusters[31:0];
      if (clusters < 64'(fbsg_pkg::FAT12_LIMIT)) begin
        r.fat_kind = fbsg_pkg::KIND_FAT12;
      end else if (clusters < 64'(fbsg_pkg::FAT16_LIMIT)) begin
        r.fat_kind    = fbsg_pkg::KIND_FAT16;
        r.entry_bytes = fbsg_pkg::FAT16_EBYTES;
        r.end_marker  = fbsg_pkg::FAT16_EOC;
        r.entry_mask  = fbsg_pkg::MASK_FAT16;
      end else begin
        r.fat_kind    = fbsg_pkg::KIND_FAT32;
        r.entry_bytes = fbsg_pkg::FAT32_EBYTES;
        r.end_marker  = fbsg_pkg::FAT32_EOC;
        r.entry_mask  = fbsg_pkg::MASK_FAT32;
      end
      return r;
    endfunction

    function void note_block(bpb_t b);
      expected_geometry.push_back(geometry_of(b));
    endfunction

    function int results_due();
      return expected_geometry.size();
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] seen);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h, got %0h", what, want, seen);
    endfunction

    function void check_result(fbsg_pkg::res_t got);
      fbsg_pkg::res_t want;
      if (expected_geometry.size() == 0) begin
        report("result with nothing pending", 64'd0, 64'd0);
        return;
      end
      want = expected_geometry.pop_front();
      if (got.status !== want.status)
        report("status", 64'(want.status), 64'(got.status));
      if (got.fat_kind !== want.fat_kind)
        report("fat_kind", 64'(want.fat_kind), 64'(got.fat_kind));
      if (got.root_dir_sectors !== want.root_dir_sectors)
        report("root_dir_sectors", 64'(want.root_dir_sectors), 64'(got.root_dir_sectors));
      if (got.fat_sectors !== want.fat_sectors)
        report("fat_sectors", 64'(want.fat_sectors), 64'(got.fat_sectors));
      if (got.cluster_count !== want.cluster_count)
        report("cluster_count", 64'(want.cluster_count), 64'(got.cluster_count));
      if (got.first_data_sector !== want.first_data_sector)
        report("first_data_sector", 64'(want.first_data_sector),
               64'(got.first_data_sector));
      if (got.entry_bytes !== want.entry_bytes)
        report("entry_bytes", 64'(want.entry_bytes), 64'(got.entry_bytes));
      if (got.end_marker !== want.end_marker)
        report("end_marker", 64'(want.end_marker), 64'(got.end_marker));
      if (got.entry_mask !== want.entry_mask)
        report("entry_mask", 64'(want.entry_mask), 64'(got.entry_mask));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  bit          quiet = 1'b0;
  int unsigned stall_cycles = 0;

  geometry_scoreboard geometry_check = new();

  fbsg_in_if  in_if ();
  fbsg_out_if out_if ();

  fat_boot_sector_geometry u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk = ~clk;

  // Well-formed block; TOT_CLUSTERS mode sets the total for the requested clusters.
  function automatic bpb_t valid_block(tot_mode_e mode, logic [63:0] clusters);
    bpb_t           b;
    fbsg_pkg::res_t pre;
    logic [63:0]    first, tot;
    int             cs;
    b.jump_first = ($urandom_range(0, 1) == 1) ? fbsg_pkg::JMP_REL16 : fbsg_pkg::JMP_REL8;
    b.jump_third = (b.jump_first == fbsg_pkg::JMP_REL16) ? 8'($urandom) : fbsg_pkg::JUMP_NOP;
    b.bytes_per_sector = 16'(1 << $urandom_range(9, 12));
    cs = int'($urandom_range(0, 7));
    b.sectors_per_cluster = 8'(1 << cs);
    b.reserved_sectors = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(1, 65535))
                                                     : 16'($urandom_range(1, 64));
    b.fat_copies = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255))
                                               : 8'($urandom_range(1, 2));
    case ($urandom_range(0, 3))
      0:       b.root_entries = 16'd0;
      1:       b.root_entries = 16'd512;
      2:       b.root_entries = 16'($urandom_range(0, 2048));
      default: b.root_entries = 16'($urandom);
    endcase
    b.media_byte = ($urandom_range(0, 3) == 0)
                   ? fbsg_pkg::MEDIA_FIXED
                   : 8'($urandom_range(fbsg_pkg::MEDIA_LOW, 8'hFF));
    case ($urandom_range(0, 3))
      0: begin
        b.fat_size_short = 16'($urandom_range(1, 65535));
        b.fat_size_long  = $urandom;
      end
      1: begin
        b.fat_size_short = 16'd0;
        b.fat_size_long  = $urandom_range(1, 8192);
      end
      2: begin
        b.fat_size_short = 16'd0;
        b.fat_size_long  = $urandom;
      end
      default: begin
        b.fat_size_short = 16'($urandom_range(1, 256));
        b.fat_size_long  = $urandom;
      end
    endcase
    b.total_sectors_short = 16'd0;
    b.total_sectors_long  = 32'd0;
    pre = geometry_scoreboard::geometry_of(b);
    first = 64'(pre.first_data_sector);
    case (mode)
      TOT_BELOW: tot = (first > 64'd16) ? first - 64'($urandom_range(1, 16)) : first - 64'd1;
      TOT_EQUAL: tot = first;
      default:   tot = first + (clusters << cs) + 64'($urandom_range(0, (1 << cs) - 1));
    endcase
    if (tot > 64'hFFFF_FFFF)
      tot = 64'hFFFF_FFFF;
    // Small totals go to the short field half the time, leaving junk in the long one.
    if (tot != 64'd0 && tot < 64'h1_0000 && $urandom_range(0, 1) == 1) begin
      b.total_sectors_short = tot[15:0];
      b.total_sectors_long  = $urandom;
    end else begin
      b.total_sectors_long  = tot[31:0];
    end
    return b;
  endfunction

  function automatic logic [63:0] pick_clusters();
    case ($urandom_range(0, 7))
      0: return 64'($urandom_range(fbsg_pkg::FAT12_LIMIT - 2, fbsg_pkg::FAT12_LIMIT + 1));
      1: return 64'($urandom_range(fbsg_pkg::FAT16_LIMIT - 2, fbsg_pkg::FAT16_LIMIT + 1));
      2: return 64'($urandom_range(0, fbsg_pkg::FAT12_LIMIT - 1));
      3: return 64'($urandom_range(fbsg_pkg::FAT12_LIMIT, fbsg_pkg::FAT16_LIMIT - 1));
      4: return 64'($urandom_range(fbsg_pkg::FAT16_LIMIT, 32'h0FFF_FFFF));
      5: return 64'($urandom_range(0, 3));
      6: return 64'($urandom);
      default: return 64'($urandom_range(0, 200000));
    endcase
  endfunction

  // Spoil exactly one of the validity checks.
  function automatic bpb_t break_block(bpb_t b);
    logic [7:0] v;
    case (fault_e'($urandom_range(0, 6)))
      BREAK_JUMP: begin
        do v = 8'($urandom); while (v == fbsg_pkg::JMP_REL16 || v == fbsg_pkg::JMP_REL8);
        b.jump_first = v;
      end
      BREAK_NOP: begin
        do v = 8'($urandom); while (v == fbsg_pkg::JUMP_NOP);
        b.jump_first = fbsg_pkg::JMP_REL8;
        b.jump_third = v;
      end
      // one flipped bit of a power of two is never a power of two
      BREAK_SECTOR:   b.bytes_per_sector ^= 16'(1 << $urandom_range(0, 15));
      BREAK_CLUSTER:  b.sectors_per_cluster ^= 8'(1 << $urandom_range(0, 7));
      BREAK_RESERVED: b.reserved_sectors = 16'd0;
      BREAK_COPIES:   b.fat_copies = 8'd0;
      default: begin
        do v = 8'($urandom);
        while (v == fbsg_pkg::MEDIA_FIXED || v >= fbsg_pkg::MEDIA_LOW);
        b.media_byte = v;
      end
    endcase
    return b;
  endfunction

  function automatic bpb_t random_block();
    bpb_t        b;
    int unsigned pick, mode;
    pick = $urandom_range(0, 19);
    mode = $urandom_range(0, 19);
    if (pick < 15 || pick < 18) begin
      if (mode < 3)
        b = valid_block(TOT_BELOW, 64'd0);
      else if (mode < 6)
        b = valid_block(TOT_EQUAL, 64'd0);
      else
        b = valid_block(TOT_CLUSTERS, pick_clusters());
      if (pick >= 15)
        b = break_block(b);
    end else begin
      b.jump_first          = 8'($urandom);
      b.jump_third          = 8'($urandom);
      b.bytes_per_sector    = 16'($urandom);
      b.sectors_per_cluster = 8'($urandom);
      b.reserved_sectors    = 16'($urandom);
      b.fat_copies          = 8'($urandom);
      b.root_entries        = 16'($urandom);
      b.total_sectors_short = 16'($urandom);
      b.media_byte          = 8'($urandom);
      b.fat_size_short      = 16'($urandom);
      b.total_sectors_long  = $urandom;
      b.fat_size_long       = $urandom;
    end
    return b;
  endfunction

  task automatic put_payload(input bpb_t b);
    in_if.jump_first          <= b.jump_first;
    in_if.jump_third          <= b.jump_third;
    in_if.bytes_per_sector    <= b.bytes_per_sector;
    in_if.sectors_per_cluster <= b.sectors_per_cluster;
    in_if.reserved_sectors    <= b.reserved_sectors;
    in_if.fat_copies          <= b.fat_copies;
    in_if.root_entries        <= b.root_entries;
    in_if.total_sectors_short <= b.total_sectors_short;
    in_if.media_byte          <= b.media_byte;
    in_if.fat_size_short      <= b.fat_size_short;
    in_if.total_sectors_long  <= b.total_sectors_long;
    in_if.fat_size_long       <= b.fat_size_long;
  endtask

  // Leave valid high on return so back-to-back blocks need no second assignment.
  task automatic send_block(input bpb_t b);
    in_if.valid <= 1'b1;
    put_payload(b);
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (geometry_check.results_due() != 0)
      @(posedge clk);
  endtask

  initial begin : receiver
    out_if.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : observe
    bpb_t           seen_block;
    fbsg_pkg::res_t seen_result;
    logic           moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_if.valid && in_if.ready) begin
        seen_block.jump_first          = in_if.jump_first;
        seen_block.jump_third          = in_if.jump_third;
        seen_block.bytes_per_sector    = in_if.bytes_per_sector;
        seen_block.sectors_per_cluster = in_if.sectors_per_cluster;
        seen_block.reserved_sectors    = in_if.reserved_sectors;
        seen_block.fat_copies          = in_if.fat_copies;
        seen_block.root_entries        = in_if.root_entries;
        seen_block.total_sectors_short = in_if.total_sectors_short;
        seen_block.media_byte          = in_if.media_byte;
        seen_block.fat_size_short      = in_if.fat_size_short;
        seen_block.total_sectors_long  = in_if.total_sectors_long;
        seen_block.fat_size_long       = in_if.fat_size_long;
        geometry_check.note_block(seen_block);
        moved = 1'b1;
      end
      if (out_if.valid && out_if.ready) begin
        seen_result.status            = fbsg_pkg::status_e'(out_if.status);
        seen_result.fat_kind          = fbsg_pkg::kind_e'(out_if.fat_kind);
        seen_result.root_dir_sectors  = out_if.root_dir_sectors;
        seen_result.fat_sectors       = out_if.fat_sectors;
        seen_result.cluster_count     = out_if.cluster_count;
        seen_result.first_data_sector = out_if.first_data_sector;
        seen_result.entry_bytes       = out_if.entry_bytes;
        seen_result.end_marker        = out_if.end_marker;
        seen_result.entry_mask        = out_if.entry_mask;
        geometry_check.check_result(seen_result);
        moved = 1'b1;
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    bpb_t b;
    in_if.valid <= 1'b0;
    put_payload('0);
    rst_n <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // type thresholds, empty data area and overhead past the total
    send_block(valid_block(TOT_CLUSTERS, 64'(fbsg_pkg::FAT12_LIMIT - 1)));
    send_block(valid_block(TOT_CLUSTERS, 64'(fbsg_pkg::FAT12_LIMIT)));
    send_block(valid_block(TOT_CLUSTERS, 64'(fbsg_pkg::FAT16_LIMIT - 1)));
    send_block(valid_block(TOT_CLUSTERS, 64'(fbsg_pkg::FAT16_LIMIT)));
    send_block(valid_block(TOT_CLUSTERS, 64'd0));
    send_block(valid_block(TOT_EQUAL, 64'd0));
    send_block(valid_block(TOT_BELOW, 64'd0));

    // jump bytes
    b = valid_block(TOT_CLUSTERS, 64'd3000);
    b.jump_first = fbsg_pkg::JMP_REL8; b.jump_third = fbsg_pkg::JUMP_NOP; send_block(b);
    b.jump_third = 8'h91; send_block(b);
    b.jump_first = 8'h00; send_block(b);

    // sector and cluster sizes, root directory extremes
    b = valid_block(TOT_CLUSTERS, 64'd3000);
    b.bytes_per_sector = 16'd0; send_block(b);
    b.bytes_per_sector = 16'hFFFF; send_block(b);
    b.bytes_per_sector = 16'd512; b.root_entries = 16'hFFFF; send_block(b);
    b = valid_block(TOT_CLUSTERS, 64'd70000);
    b.sectors_per_cluster = 8'd0; send_block(b);
    b.sectors_per_cluster = 8'hFF; send_block(b);
    b.sectors_per_cluster = 8'd128; send_block(b);

    // counts and media
    b = valid_block(TOT_CLUSTERS, 64'd20000);
    b.reserved_sectors = 16'd0; send_block(b);
    b.reserved_sectors = 16'hFFFF; send_block(b);
    b.fat_copies = 8'd0; send_block(b);
    b.fat_copies = 8'hFF; b.fat_size_short = 16'd0; b.fat_size_long = 32'hFFFF_FFFF;
    send_block(b);
    b = valid_block(TOT_CLUSTERS, 64'd20000);
    b.media_byte = 8'hEF; send_block(b);
    b.media_byte = 8'hF7; send_block(b);
    b.media_byte = fbsg_pkg::MEDIA_FIXED; send_block(b);
    b.media_byte = 8'hFF; send_block(b);
    send_block('1);
    send_block('0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_ITEMS)
        quiet = 1'b1;
      if (i == RANDOM_ITEMS / 2) begin
        // hold off until the pipeline has fully emptied
        in_if.valid <= 1'b0;
        drain_results();
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      send_block(random_block());
    end
    in_if.valid <= 1'b0;
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (geometry_check.mismatches == 0 && geometry_check.results_due() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end
endmodule

/* fat_boot_sector_geometry.f */
+incdir+rtl
rtl/fbsg_pkg.sv
rtl/fbsg_in_if.sv
rtl/fbsg_out_if.sv
rtl/fbsg_decode.sv
rtl/fbsg_span.sv
rtl/fbsg_classify.sv
rtl/fat_boot_sector_geometry.sv
verif/fat_boot_sector_geometry_tb.sv
